// ===== src/extendible_hash_table_top_macros.svh =====
// ---------------------------------------------------------------------------
// Extendible hash table assertion macros
// Shared wrappers for the concurrent assertions of the checker.
// ---------------------------------------------------------------------------
`ifndef EXTENDIBLE_HASH_TABLE_TOP_MACROS_SVH
`define EXTENDIBLE_HASH_TABLE_TOP_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define EHT_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// A condition that must be followed by another one in the next cycle.
`define EHT_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== src/eht_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Extendible hash table package
// Configuration width and reset value, request and status codes, and the fixed widths of the result fields.
// ---------------------------------------------------------------------------
package eht_pkg;

	// Configuration register.
	localparam int CFG_W = 4;
	localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

	// Request codes.
	localparam int REQ_W = 2;
	localparam logic [REQ_W-1:0] REQ_FIND   = 2'd0;
	localparam logic [REQ_W-1:0] REQ_INSERT = 2'd1;
	localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;

	// Status codes.
	localparam int STATUS_W = 2;
	localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_REJECT    = 2'd2;

	// Result field widths.
	localparam int GD_OUT_W  = 4;
	localparam int CNT_OUT_W = 9;
	localparam int LD_OUT_W  = 5;

endpackage

// ===== src/eht_req_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one table operation.
// ---------------------------------------------------------------------------
interface eht_req_if #(
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 32
);
	import eht_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [REQ_W-1:0]      req_type;
	logic [KEY_BITS-1:0]   key;
	logic [VALUE_BITS-1:0] value;

	modport source (output valid, output req_type, output key, output value, input ready);
	modport sink (input valid, input req_type, input key, input value, output ready);
endinterface

// ===== src/eht_rsp_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries the result of one table operation.
// ---------------------------------------------------------------------------
interface eht_rsp_if #(
	parameter int VALUE_BITS = 32
);
	import eht_pkg::*;

	logic                       valid;
	logic                       ready;
	logic [STATUS_W-1:0]        status;
	logic [VALUE_BITS-1:0]      found_value;
	logic [GD_OUT_W-1:0]        global_depth;
	logic [CNT_OUT_W-1:0]       bucket_count;
	logic signed [LD_OUT_W-1:0] local_depth;

	modport source (output valid, output status, output found_value, output global_depth,
		output bucket_count, output local_depth, input ready);
	modport sink (input valid, input status, input found_value, input global_depth,
		input bucket_count, input local_depth, output ready);
endinterface

// ===== src/eht_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Simple dual-port RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module eht_ram #(
	parameter int AW = 8,
	parameter int DW = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);
	logic [DW-1:0] mem [(1 << AW)];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port with registered read data.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule

// ===== src/extendible_hash_table_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Extendible hash table
// Key/value table with a directory indexed by the low key bits, buckets of
// fixed slot count, and bucket splitting with directory doubling on insert.
// ---------------------------------------------------------------------------
//  channel    | direction | content
//  request    | in        | req_type, key, value
//  response   | out       | status, found_value, global_depth, bucket_count,
//             |           | local_depth
//  cfg        | in        | bucket_capacity write, no read-back
//
// One operation at a time. Find, remove and insert scan the slot memory
// one slot per cycle, stopping at a match. An insert of a present key
// rewrites its value; a new key goes to a free slot or splits the bucket.
// Each split scans the bucket, moves keys to the new bucket and rewrites the
// directory; a directory doubling before it copies the directory first.
// No clearing pass after reset: the table is usable as soon as reset ends.
// A stalled response holds the block before it takes the next request.
module extendible_hash_table_top #(
	parameter int MAX_GLOBAL_DEPTH = 8,
	parameter int BUCKET_SLOTS     = 8,
	parameter int KEY_BITS         = 32,
	parameter int VALUE_BITS       = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [eht_pkg::CFG_W-1:0]   cfg_wdata,
	eht_req_if.sink                     request,
	eht_rsp_if.source                   response
);
	import eht_pkg::*;

	localparam int AW       = MAX_GLOBAL_DEPTH;
	localparam int DIR_SIZE = 1 << AW;
	localparam int CNT_W    = AW + 1;
	localparam int GD_W     = $clog2(MAX_GLOBAL_DEPTH + 1);
	localparam int FILL_W   = $clog2(BUCKET_SLOTS + 1);
	localparam int SW       = (BUCKET_SLOTS > 1) ? $clog2(BUCKET_SLOTS) : 1;
	localparam int SA_W     = AW + SW;
	localparam int CW       = (FILL_W > CFG_W) ? FILL_W : CFG_W;
	localparam int KX_W     = (KEY_BITS > CNT_W) ? KEY_BITS : CNT_W;
	localparam int MW       = BUCKET_SLOTS + 1;
	localparam int META_W   = GD_W + FILL_W + BUCKET_SLOTS;
	localparam int SLOT_DW  = KEY_BITS + VALUE_BITS;
	localparam logic [SW-1:0] LAST_SLOT = SW'(BUCKET_SLOTS - 1);

	// Sequencer states.
	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_LOOK    = 4'd1;
	localparam logic [3:0] ST_DIR     = 4'd2;
	localparam logic [3:0] ST_META    = 4'd3;
	localparam logic [3:0] ST_SCAN    = 4'd4;
	localparam logic [3:0] ST_ACT     = 4'd5;
	localparam logic [3:0] ST_DECIDE  = 4'd6;
	localparam logic [3:0] ST_DOUBLE  = 4'd7;
	localparam logic [3:0] ST_SPLIT   = 4'd8;
	localparam logic [3:0] ST_META_B  = 4'd9;
	localparam logic [3:0] ST_META_NB = 4'd10;
	localparam logic [3:0] ST_DIRUPD  = 4'd11;
	localparam logic [3:0] ST_FINISH  = 4'd12;

	logic [3:0]              state_q;
	logic [CFG_W-1:0]        cfg_q;
	logic [GD_W-1:0]         depth_q;
	logic [CNT_W-1:0]        made_q;
	logic                    meta0_q;
	logic                    out_valid_q;

	logic [REQ_W-1:0]        req_q;
	logic [KEY_BITS-1:0]     key_q;
	logic [VALUE_BITS-1:0]   val_q;
	logic [FILL_W-1:0]       cap_q;
	logic                    retry_q;
	logic [AW-1:0]           b_q;
	logic [GD_W-1:0]         bd_q;
	logic [FILL_W-1:0]       bf_q;
	logic [BUCKET_SLOTS-1:0] bm_q;
	logic                    hit_q;
	logic [SW-1:0]           hit_pos_q;
	logic [SW-1:0]           idx_q;
	logic [FILL_W-1:0]       n_q;
	logic [CNT_W-1:0]        swp_q;
	logic [STATUS_W-1:0]     status_q;
	logic [VALUE_BITS-1:0]   found_q;

	logic [STATUS_W-1:0]        out_status_q;
	logic [VALUE_BITS-1:0]      out_found_q;
	logic [GD_OUT_W-1:0]        out_gd_q;
	logic [CNT_OUT_W-1:0]       out_cnt_q;
	logic signed [LD_OUT_W-1:0] out_ld_q;

	// Memory ports.
	logic                dir_we;
	logic [AW-1:0]       dir_wa, dir_wd, dir_ra, dir_rd;
	logic                meta_we;
	logic [AW-1:0]       meta_wa, meta_ra;
	logic [META_W-1:0]   meta_wd, meta_rd, meta_eff;
	logic                slot_we;
	logic [SA_W-1:0]     slot_wa, slot_ra;
	logic [SLOT_DW-1:0]  slot_wd, slot_rd;

	logic [KX_W-1:0]         key_ext, slot_kx_sh;
	logic [AW-1:0]           dir_mask, key_idx, dir_b, prev_ent;
	logic [CNT_W-1:0]        len, sw_prev, prev_sh;
	logic [KEY_BITS-1:0]     slot_key;
	logic [VALUE_BITS-1:0]   slot_val;
	logic                    match, moving, out_free;
	logic [SW-1:0]           free_pos;
	logic [CW-1:0]           cfg_ext;
	logic [FILL_W-1:0]       cap_clamp;
	logic [BUCKET_SLOTS-1:0] nb_mask, hit_bit, free_bit, idx_bit;

	eht_ram #(.AW(AW), .DW(AW)) u_dir (
		.clk(clk), .we(dir_we), .waddr(dir_wa), .wdata(dir_wd),
		.raddr(dir_ra), .rdata(dir_rd)
	);

	eht_ram #(.AW(AW), .DW(META_W)) u_meta (
		.clk(clk), .we(meta_we), .waddr(meta_wa), .wdata(meta_wd),
		.raddr(meta_ra), .rdata(meta_rd)
	);

	eht_ram #(.AW(SA_W), .DW(SLOT_DW)) u_slot (
		.clk(clk), .we(slot_we), .waddr(slot_wa), .wdata(slot_wd),
		.raddr(slot_ra), .rdata(slot_rd)
	);

	// Directory index of the key and derived lookup values.
	assign key_ext  = KX_W'(key_q);
	assign len      = CNT_W'(1) << depth_q;
	assign dir_mask = AW'(len - CNT_W'(1));
	assign key_idx  = key_ext[AW-1:0] & dir_mask;
	// Directory entry zero is never rewritten and always names bucket zero.
	assign dir_b    = (key_idx == '0) ? '0 : dir_rd;
	assign sw_prev  = swp_q - CNT_W'(1);
	assign prev_ent = (sw_prev[AW-1:0] == '0) ? '0 : dir_rd;
	assign prev_sh  = sw_prev >> bd_q;
	// Bucket zero holds its reset contents until first written.
	assign meta_eff = ((b_q == '0) && !meta0_q) ? '0 : meta_rd;

	assign slot_key   = slot_rd[SLOT_DW-1 -: KEY_BITS];
	assign slot_val   = slot_rd[VALUE_BITS-1:0];
	assign slot_kx_sh = KX_W'(slot_key) >> bd_q;
	assign match      = bm_q[idx_q] && (slot_key == key_q);
	assign moving     = bm_q[idx_q] && slot_kx_sh[0];
	assign out_free   = !out_valid_q || response.ready;

	assign hit_bit  = BUCKET_SLOTS'(1) << hit_pos_q;
	assign free_bit = BUCKET_SLOTS'(1) << free_pos;
	assign idx_bit  = BUCKET_SLOTS'(1) << idx_q;
	assign nb_mask  = BUCKET_SLOTS'((MW'(1) << n_q) - MW'(1));

	// Capacity clamped to the slot count, zero acting as one.
	assign cfg_ext = CW'(cfg_q);
	always_comb begin
		if (cfg_q == '0) begin
			cap_clamp = FILL_W'(1);
		end else if (cfg_ext > CW'(BUCKET_SLOTS)) begin
			cap_clamp = FILL_W'(BUCKET_SLOTS);
		end else begin
			cap_clamp = FILL_W'(cfg_q);
		end
	end

	// Lowest free slot of the current bucket.
	always_comb begin
		free_pos = '0;
		for (int s = BUCKET_SLOTS - 1; s >= 0; s--) begin
			if (!bm_q[s]) begin
				free_pos = SW'(s);
			end
		end
	end

	// Memory addressing and writes for each state.
	always_comb begin
		dir_ra  = key_idx;
		dir_we  = 1'b0;
		dir_wa  = sw_prev[AW-1:0];
		dir_wd  = prev_ent;
		meta_ra = b_q;
		meta_we = 1'b0;
		meta_wa = b_q;
		meta_wd = {bd_q, bf_q, bm_q};
		slot_ra = {b_q, idx_q + SW'(1)};
		slot_we = 1'b0;
		slot_wa = {b_q, hit_pos_q};
		slot_wd = {key_q, val_q};
		case (state_q)
			ST_DIR: begin
				meta_ra = dir_b;
			end
			ST_META: begin
				slot_ra = {b_q, SW'(0)};
			end
			ST_ACT: begin
				if (hit_q && (req_q == REQ_REMOVE)) begin
					meta_we = 1'b1;
					meta_wd = {bd_q, bf_q - FILL_W'(1), bm_q & ~hit_bit};
				end
				if (hit_q && (req_q == REQ_INSERT)) begin
					slot_we = 1'b1;
				end
			end
			ST_DECIDE: begin
				slot_ra = {b_q, SW'(0)};
				if (bf_q < cap_q) begin
					slot_we = 1'b1;
					slot_wa = {b_q, free_pos};
					meta_we = 1'b1;
					meta_wd = {bd_q, bf_q + FILL_W'(1), bm_q | free_bit};
				end
			end
			ST_DOUBLE: begin
				dir_ra  = swp_q[AW-1:0];
				slot_ra = {b_q, SW'(0)};
				if (swp_q != '0) begin
					dir_we = 1'b1;
					dir_wa = sw_prev[AW-1:0] + len[AW-1:0];
				end
			end
			ST_SPLIT: begin
				if (moving) begin
					slot_we = 1'b1;
					slot_wa = {made_q[AW-1:0], n_q[SW-1:0]};
					slot_wd = slot_rd;
				end
			end
			ST_META_B: begin
				meta_we = 1'b1;
				meta_wd = {bd_q + GD_W'(1), bf_q, bm_q};
			end
			ST_META_NB: begin
				meta_we = 1'b1;
				meta_wa = made_q[AW-1:0];
				meta_wd = {bd_q + GD_W'(1), n_q, nb_mask};
			end
			ST_DIRUPD: begin
				dir_ra = swp_q[AW-1:0];
				if ((swp_q != '0) && (prev_ent == b_q) && prev_sh[0]) begin
					dir_we = 1'b1;
					dir_wd = made_q[AW-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	// Sequencer and table-wide state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cfg_q   <= CFG_RESET;
			depth_q <= '0;
			made_q  <= CNT_W'(1);
			meta0_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cfg_q <= cfg_wdata;
			end
			if (meta_we && (meta_wa == '0)) begin
				meta0_q <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (request.valid) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					state_q <= ST_DIR;
				end
				ST_DIR: begin
					state_q <= ST_META;
				end
				ST_META: begin
					if (retry_q) begin
						state_q <= ST_DECIDE;
					end else if ((req_q == REQ_FIND) || (req_q == REQ_INSERT)
							|| (req_q == REQ_REMOVE)) begin
						state_q <= ST_SCAN;
					end else begin
						state_q <= ST_FINISH;
					end
				end
				ST_SCAN: begin
					if (match || (idx_q == LAST_SLOT)) begin
						state_q <= ST_ACT;
					end
				end
				ST_ACT: begin
					if ((req_q == REQ_INSERT) && !hit_q) begin
						state_q <= ST_DECIDE;
					end else begin
						state_q <= ST_FINISH;
					end
				end
				ST_DECIDE: begin
					if (bf_q < cap_q) begin
						state_q <= ST_FINISH;
					end else if ((bd_q >= GD_W'(MAX_GLOBAL_DEPTH))
							|| (made_q >= CNT_W'(DIR_SIZE))) begin
						state_q <= ST_FINISH;
					end else if (bd_q == depth_q) begin
						state_q <= ST_DOUBLE;
					end else begin
						state_q <= ST_SPLIT;
					end
				end
				ST_DOUBLE: begin
					if (swp_q == len) begin
						depth_q <= depth_q + GD_W'(1);
						state_q <= ST_SPLIT;
					end
				end
				ST_SPLIT: begin
					if (idx_q == LAST_SLOT) begin
						state_q <= ST_META_B;
					end
				end
				ST_META_B: begin
					state_q <= ST_META_NB;
				end
				ST_META_NB: begin
					state_q <= ST_DIRUPD;
				end
				ST_DIRUPD: begin
					if (swp_q == len) begin
						made_q  <= made_q + CNT_W'(1);
						state_q <= ST_LOOK;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Working registers of the current operation.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				req_q   <= request.req_type;
				key_q   <= request.key;
				val_q   <= request.value;
				cap_q   <= cap_clamp;
				retry_q <= 1'b0;
			end
			ST_DIR: begin
				b_q <= dir_b;
			end
			ST_META: begin
				{bd_q, bf_q, bm_q} <= meta_eff;
				idx_q    <= '0;
				status_q <= STATUS_NOT_FOUND;
				found_q  <= '0;
			end
			ST_SCAN: begin
				hit_q     <= match;
				hit_pos_q <= idx_q;
				found_q   <= slot_val;
				idx_q     <= idx_q + SW'(1);
			end
			ST_ACT: begin
				found_q  <= '0;
				status_q <= hit_q ? STATUS_OK : STATUS_NOT_FOUND;
				if (hit_q && (req_q == REQ_FIND)) begin
					found_q <= found_q;
				end
				if (hit_q && (req_q == REQ_REMOVE)) begin
					bf_q <= bf_q - FILL_W'(1);
					bm_q <= bm_q & ~hit_bit;
				end
			end
			ST_DECIDE: begin
				idx_q <= '0;
				n_q   <= '0;
				swp_q <= '0;
				if (bf_q < cap_q) begin
					bf_q     <= bf_q + FILL_W'(1);
					bm_q     <= bm_q | free_bit;
					status_q <= STATUS_OK;
				end else begin
					status_q <= STATUS_REJECT;
				end
			end
			ST_DOUBLE: begin
				swp_q <= swp_q + CNT_W'(1);
			end
			ST_SPLIT: begin
				idx_q <= idx_q + SW'(1);
				if (moving) begin
					n_q  <= n_q + FILL_W'(1);
					bf_q <= bf_q - FILL_W'(1);
					bm_q <= bm_q & ~idx_bit;
				end
			end
			ST_META_NB: begin
				swp_q <= '0;
			end
			ST_DIRUPD: begin
				swp_q   <= swp_q + CNT_W'(1);
				retry_q <= 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Output register: loaded when the result is ready and the slot is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_FINISH) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (response.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_FINISH) && out_free) begin
			out_status_q <= status_q;
			out_found_q  <= found_q;
			out_gd_q     <= GD_OUT_W'(depth_q);
			out_cnt_q    <= CNT_OUT_W'(made_q);
			out_ld_q     <= (bf_q == '0) ? '1 : LD_OUT_W'(bd_q);
		end
	end

	assign request.ready         = (state_q == ST_IDLE);
	assign response.valid        = out_valid_q;
	assign response.status       = out_status_q;
	assign response.found_value  = out_found_q;
	assign response.global_depth = out_gd_q;
	assign response.bucket_count = out_cnt_q;
	assign response.local_depth  = out_ld_q;
endmodule

// ===== src/eht_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Extendible hash table checker
// Port-level assertions on the request and response channels.
// ---------------------------------------------------------------------------
`include "extendible_hash_table_top_macros.svh"

module eht_checker #(
	parameter int VALUE_BITS = 32
) (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                req_valid,
	input logic                                req_ready,
	input logic                                rsp_valid,
	input logic                                rsp_ready,
	input logic [eht_pkg::STATUS_W-1:0]        rsp_status,
	input logic [VALUE_BITS-1:0]               rsp_found_value,
	input logic [eht_pkg::GD_OUT_W-1:0]        rsp_global_depth,
	input logic signed [eht_pkg::LD_OUT_W-1:0] rsp_local_depth
);
	import eht_pkg::*;

	// A stalled result stays offered.
	`EHT_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")

	// One operation at a time: no request taken in the cycle after a transfer.
	`EHT_ASSERT_NEXT(a_one_op, clk, arst_n, req_valid && req_ready, !req_ready, "request taken while busy")

	// A value is only returned by a successful find.
	`EHT_ASSERT(a_found_zero, clk, arst_n, !rsp_valid || rsp_status == STATUS_OK || rsp_found_value == '0, "found value on a failed result")

	// A bucket is never deeper than the directory.
	`EHT_ASSERT(a_depth_order, clk, arst_n, !rsp_valid || rsp_local_depth[LD_OUT_W-1] || (rsp_local_depth[GD_OUT_W-1:0] <= rsp_global_depth), "local depth above global depth")
endmodule

bind extendible_hash_table_top eht_checker #(.VALUE_BITS(VALUE_BITS)) u_eht_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (request.valid),
	.req_ready        (request.ready),
	.rsp_valid        (response.valid),
	.rsp_ready        (response.ready),
	.rsp_status       (response.status),
	.rsp_found_value  (response.found_value),
	.rsp_global_depth (response.global_depth),
	.rsp_local_depth  (response.local_depth)
);
